@@ rtl/fawc_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and helpers of the fully associative write-back cache
package fawc_pkg;

  localparam int ADDR_W = 32;
  localparam int DATA_W = 64;
  localparam int BE_W = 8;
  localparam int SEED_W = 16;

  localparam int DEF_LINES = 64;
  localparam int DEF_WPL = 8;
  localparam int DEF_ADDR_BITS = 32;

  localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [SEED_W-1:0] LFSR_ONE = 16'h0001;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_READ  = 3'd0,
    KIND_ACK   = 3'd1,
    KIND_FILL  = 3'd2,
    KIND_WB    = 3'd3,
    KIND_BUSY  = 3'd4
  } resp_kind_t;

  function automatic logic [DATA_W-1:0] byte_merge(input logic [DATA_W-1:0] old_word,
                                                   input logic [DATA_W-1:0] new_word,
                                                   input logic [BE_W-1:0] be);
    logic [DATA_W-1:0] res;
    res = old_word;
    for (int b = 0; b < BE_W; b++) begin
      if (be[b]) begin
        res[8*b +: 8] = new_word[8*b +: 8];
      end
    end
    return res;
  endfunction

  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
    return (v >> 1) ^ (v[0] ? LFSR_TAPS : '0);
  endfunction

endpackage

@@ rtl/fawc_req_if.sv @@
`timescale 1ns / 1ps
// request channel: reads, writes and fill words
interface fawc_req_if import fawc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] data_word;
  logic [BE_W-1:0]   byte_enable;

  modport source (output valid, opcode, address, data_word, byte_enable, input ready);
  modport sink (input valid, opcode, address, data_word, byte_enable, output ready);
endinterface

@@ rtl/fawc_resp_if.sv @@
`timescale 1ns / 1ps
// response channel: read data, acks, fill requests, writebacks, rejects
interface fawc_resp_if import fawc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        resp_kind;
  logic [ADDR_W-1:0] resp_addr;
  logic [DATA_W-1:0] resp_data;
  logic              resp_last;

  modport source (output valid, resp_kind, resp_addr, resp_data, resp_last, input ready);
  modport sink (input valid, resp_kind, resp_addr, resp_data, resp_last, output ready);
endinterface

@@ rtl/fully_assoc_writeback_cache_top.sv @@
`timescale 1ns / 1ps
// hit: S_LOOK, then S_HIT registers the result; the next transaction is accepted after it
// miss or busy: S_LOOK registers the result, then the next transaction is accepted
// last fill word: S_FILL writes the line, S_DONE registers the result; if full, S_VICT first
// when full, WORDS_PER_LINE writeback results come first; victim is low SLOT_W bits of lfsr
// other fill words, ignored ops stay in S_IDLE; resp.ready stalls hold emitting states
// sync reset clears valid bits, occupancy, miss state; lfsr loads 1; no clearing pass
module fully_assoc_writeback_cache_top import fawc_pkg::*; #(
  parameter int LINES = DEF_LINES,
  parameter int WORDS_PER_LINE = DEF_WPL,
  parameter int ADDR_BITS = DEF_ADDR_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SEED_W-1:0] cfg_wr_data,
  fawc_req_if.sink          req,
  fawc_resp_if.source       resp
);
  localparam int AW = ADDR_BITS;
  localparam int OFF_W = $clog2(WORDS_PER_LINE * 8);
  localparam int TAG_W = AW - OFF_W;
  localparam int SLOT_W = $clog2(LINES);
  localparam int WIDX_W = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
  localparam int OCC_W = $clog2(LINES + 1);
  localparam int MEM_AW = $clog2(LINES * WORDS_PER_LINE);
  localparam logic [WIDX_W-1:0] LAST_IDX = WIDX_W'(WORDS_PER_LINE - 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOOK = 9'b000000010,
    S_HIT  = 9'b000000100,
    S_VICT = 9'b000001000,
    S_WBRD = 9'b000010000,
    S_WBEM = 9'b000100000,
    S_FILL = 9'b001000000,
    S_DONE = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [1:0]        cur_op;
  logic [AW-1:0]     cur_addr;
  logic [DATA_W-1:0] cur_data;
  logic [BE_W-1:0]   cur_be;
  logic [1:0]        pend_op;
  logic [AW-1:0]     pend_addr;
  logic [DATA_W-1:0] pend_data;
  logic [BE_W-1:0]   pend_be;
  logic              miss_pending;
  logic [WIDX_W-1:0] fill_count;
  logic [DATA_W-1:0] fill_buf [WORDS_PER_LINE];
  logic [OCC_W-1:0]  occupancy;
  logic [SEED_W-1:0] lfsr;
  logic [SLOT_W-1:0] slot;
  logic [WIDX_W-1:0] wb_idx;

  logic              o_valid;
  logic [2:0]        o_kind;
  logic [ADDR_W-1:0] o_addr;
  logic [DATA_W-1:0] o_data;
  logic              o_last;

  logic              acc, out_free, full, fill_done;
  logic              emit, e_last;
  resp_kind_t        e_kind;
  logic [ADDR_W-1:0] e_addr;
  logic [DATA_W-1:0] e_data;

  logic              cam_hit, cam_we;
  logic [SLOT_W-1:0] cam_slot;
  logic              mem_we, mem_re, tag_re, tag_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;
  logic [TAG_W-1:0]  tag_rdata;
  logic [AW-1:0]     in_addr;

  function automatic logic [WIDX_W-1:0] word_idx(input logic [AW-1:0] a);
    return WIDX_W'((a >> 3) % WORDS_PER_LINE);
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [AW-1:0] a);
    return TAG_W'(a >> OFF_W);
  endfunction

  function automatic logic [MEM_AW-1:0] mem_addr(input logic [SLOT_W-1:0] s,
                                                 input logic [WIDX_W-1:0] w);
    return MEM_AW'(MEM_AW'(s) * MEM_AW'(WORDS_PER_LINE)) + MEM_AW'(w);
  endfunction

  assign in_addr = AW'(req.address);
  assign req.ready = (state == S_IDLE);
  assign acc = req.valid && req.ready;
  assign out_free = !o_valid || resp.ready;
  assign full = (occupancy == OCC_W'(LINES));
  assign fill_done = miss_pending && (fill_count == LAST_IDX);

  assign resp.valid = o_valid;
  assign resp.resp_kind = o_kind;
  assign resp.resp_addr = o_addr;
  assign resp.resp_data = o_data;
  assign resp.resp_last = o_last;

  fawc_tag_cam #(.LINES(LINES), .TAG_W(TAG_W)) u_cam (
    .clk        (clk),
    .rst        (rst),
    .lookup_en  (acc),
    .lookup_tag (tag_of(in_addr)),
    .wr_en      (cam_we),
    .wr_slot    (slot),
    .wr_tag     (tag_of(pend_addr)),
    .hit        (cam_hit),
    .hit_slot   (cam_slot)
  );

  fawc_mem #(.LINES(LINES), .WORDS_PER_LINE(WORDS_PER_LINE), .TAG_W(TAG_W)) u_mem (
    .clk        (clk),
    .word_we    (mem_we),
    .word_waddr (mem_waddr),
    .word_wdata (mem_wdata),
    .word_re    (mem_re),
    .word_raddr (mem_raddr),
    .word_rdata (mem_rdata),
    .tag_we     (tag_we),
    .tag_waddr  (slot),
    .tag_wdata  (tag_of(pend_addr)),
    .tag_re     (tag_re),
    .tag_raddr  (lfsr[SLOT_W-1:0]),
    .tag_rdata  (tag_rdata)
  );

  always_comb begin
    state_next = state;
    emit = 1'b0;
    e_kind = KIND_READ;
    e_addr = ADDR_W'(cur_addr);
    e_data = '0;
    e_last = 1'b1;
    mem_re = 1'b0;
    mem_raddr = mem_addr(cam_slot, word_idx(cur_addr));
    mem_we = 1'b0;
    mem_waddr = mem_addr(cam_slot, word_idx(cur_addr));
    mem_wdata = byte_merge(mem_rdata, cur_data, cur_be);
    tag_re = 1'b0;
    tag_we = 1'b0;
    cam_we = 1'b0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (req.opcode)
            OP_READ, OP_WRITE: state_next = S_LOOK;
            OP_FILL: begin
              if (fill_done) begin
                state_next = full ? S_VICT : S_FILL;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_LOOK: begin
        if (!miss_pending && cam_hit) begin
          mem_re = 1'b1;
          state_next = S_HIT;
        end else if (out_free) begin
          emit = 1'b1;
          if (miss_pending) begin
            e_kind = KIND_BUSY;
          end else begin
            e_kind = KIND_FILL;
            e_addr = ADDR_W'({tag_of(cur_addr), OFF_W'(0)});
          end
          state_next = S_IDLE;
        end
      end
      S_HIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (cur_op == OP_WRITE) begin
            e_kind = KIND_ACK;
            mem_we = 1'b1;
          end else begin
            e_data = mem_rdata;
          end
          state_next = S_IDLE;
        end
      end
      S_VICT: begin
        tag_re = 1'b1;
        state_next = S_WBRD;
      end
      S_WBRD: begin
        mem_re = 1'b1;
        mem_raddr = mem_addr(slot, wb_idx);
        state_next = S_WBEM;
      end
      S_WBEM: begin
        if (out_free) begin
          emit = 1'b1;
          e_kind = KIND_WB;
          e_addr = ADDR_W'(AW'({tag_rdata, OFF_W'(0)}) + (AW'(wb_idx) << 3));
          e_data = mem_rdata;
          e_last = 1'b0;
          state_next = (wb_idx == LAST_IDX) ? S_FILL : S_WBRD;
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
        mem_waddr = mem_addr(slot, wb_idx);
        mem_wdata = (pend_op == OP_WRITE && wb_idx == word_idx(pend_addr)) ?
                    byte_merge(fill_buf[wb_idx], pend_data, pend_be) : fill_buf[wb_idx];
        if (wb_idx == LAST_IDX) begin
          cam_we = 1'b1;
          tag_we = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          e_addr = ADDR_W'(pend_addr);
          if (pend_op == OP_WRITE) begin
            e_kind = KIND_ACK;
          end else begin
            e_data = fill_buf[word_idx(pend_addr)];
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      miss_pending <= 1'b0;
      fill_count <= '0;
      occupancy <= '0;
      lfsr <= LFSR_ONE;
      o_valid <= 1'b0;
      wb_idx <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (resp.ready) begin
        o_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        lfsr <= (cfg_wr_data == '0) ? LFSR_ONE : cfg_wr_data;
      end else if (acc && req.opcode == OP_FILL && fill_done && full) begin
        lfsr <= lfsr_step(lfsr);
      end
      if (acc && req.opcode == OP_FILL && miss_pending) begin
        fill_count <= fill_done ? '0 : fill_count + 1'b1;
        wb_idx <= '0;
      end
      if (state == S_LOOK && !miss_pending && !cam_hit && out_free) begin
        miss_pending <= 1'b1;
        fill_count <= '0;
      end
      if (state == S_WBEM && out_free) begin
        wb_idx <= (wb_idx == LAST_IDX) ? '0 : wb_idx + 1'b1;
      end
      if (state == S_FILL) begin
        wb_idx <= (wb_idx == LAST_IDX) ? '0 : wb_idx + 1'b1;
        if (wb_idx == LAST_IDX) begin
          miss_pending <= 1'b0;
          if (!full) begin
            occupancy <= occupancy + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cur_op <= req.opcode;
      cur_addr <= in_addr;
      cur_data <= req.data_word;
      cur_be <= req.byte_enable;
      if (req.opcode == OP_FILL && miss_pending) begin
        fill_buf[fill_count] <= req.data_word;
      end
      if (req.opcode == OP_FILL && fill_done) begin
        slot <= SLOT_W'(occupancy);
      end
    end
    if (state == S_VICT) begin
      slot <= lfsr[SLOT_W-1:0];
    end
    if (state == S_LOOK && !miss_pending && !cam_hit && out_free) begin
      pend_op <= cur_op;
      pend_addr <= cur_addr;
      pend_data <= cur_data;
      pend_be <= cur_be;
    end
    if (emit) begin
      o_kind <= e_kind;
      o_addr <= e_addr;
      o_data <= e_data;
      o_last <= e_last;
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(LINES))
    else $error("occupancy above line count");

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (rst)
    lfsr != '0)
    else $error("replacement lfsr locked at zero");

  a_miss_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(miss_pending) |-> state == S_DONE)
    else $error("miss cleared outside line install");

  a_fill_idle: assert property (@(posedge clk) disable iff (rst)
    !miss_pending |-> fill_count == '0)
    else $error("fill words counted with no miss pending");

  a_install_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_VICT || state == S_FILL) |-> miss_pending)
    else $error("line install without a pending miss");
`endif
endmodule

@@ rtl/fawc_tag_cam.sv @@
`timescale 1ns / 1ps
// tag match array with valid bits and a registered hit vector
module fawc_tag_cam import fawc_pkg::*; #(
  parameter int LINES = DEF_LINES,
  parameter int TAG_W = 26
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     lookup_en,
  input  logic [TAG_W-1:0]         lookup_tag,
  input  logic                     wr_en,
  input  logic [$clog2(LINES)-1:0] wr_slot,
  input  logic [TAG_W-1:0]         wr_tag,
  output logic                     hit,
  output logic [$clog2(LINES)-1:0] hit_slot
);
  localparam int SLOT_W = $clog2(LINES);

  logic [LINES-1:0] valid;
  logic [TAG_W-1:0] tags [LINES];
  logic [LINES-1:0] hit_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tags[wr_slot] <= wr_tag;
    end
    if (lookup_en) begin
      for (int i = 0; i < LINES; i++) begin
        hit_vec[i] <= valid[i] && (tags[i] == lookup_tag);
      end
    end
  end

  assign hit = |hit_vec;

  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < LINES; i++) begin
      if (hit_vec[i]) begin
        hit_slot = hit_slot | SLOT_W'(i);
      end
    end
  end
endmodule

@@ rtl/fawc_mem.sv @@
`timescale 1ns / 1ps
// line word memory and victim tag memory, synchronous read
module fawc_mem import fawc_pkg::*; #(
  parameter int LINES = DEF_LINES,
  parameter int WORDS_PER_LINE = DEF_WPL,
  parameter int TAG_W = 26
) (
  input  logic                                    clk,
  input  logic                                    word_we,
  input  logic [$clog2(LINES*WORDS_PER_LINE)-1:0] word_waddr,
  input  logic [DATA_W-1:0]                       word_wdata,
  input  logic                                    word_re,
  input  logic [$clog2(LINES*WORDS_PER_LINE)-1:0] word_raddr,
  output logic [DATA_W-1:0]                       word_rdata,
  input  logic                                    tag_we,
  input  logic [$clog2(LINES)-1:0]                tag_waddr,
  input  logic [TAG_W-1:0]                        tag_wdata,
  input  logic                                    tag_re,
  input  logic [$clog2(LINES)-1:0]                tag_raddr,
  output logic [TAG_W-1:0]                        tag_rdata
);
  logic [DATA_W-1:0] words [LINES*WORDS_PER_LINE];
  logic [TAG_W-1:0]  tag_ram [LINES];

  always_ff @(posedge clk) begin
    if (word_we) begin
      words[word_waddr] <= word_wdata;
    end
    if (word_re) begin
      word_rdata <= words[word_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_ram[tag_waddr] <= tag_wdata;
    end
    if (tag_re) begin
      tag_rdata <= tag_ram[tag_raddr];
    end
  end
endmodule
